### sv/dda_line_rasterizer_core_assert.svh
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core_assert.svh
// Assertion macros shared by the line rasterizer RTL.
// The macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

    // Fixed port widths.
    localparam int FIELD_W    = 6;
    localparam int COLOR_W    = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } dlr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a new line and clear the stepper
        logic emit;     // write one result into the output register
    } dlr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic final_step;   // the next result is the last one of the line
    } dlr_status_t;

endpackage

`default_nettype wire

### sv/dlr_ctrl.sv
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer for the line rasterizer: accepts a request, then steps the
// datapath once per free output slot until the final result is written.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dlr_pkg::dlr_status_t status,
    output dlr_pkg::dlr_cmd_t        cmd
);
    import dlr_pkg::*;

    dlr_state_t state_reg;
    dlr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.final_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Line setup, DDA stepper and output register of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_datapath #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dlr_pkg::dlr_cmd_t             cmd,
    output dlr_pkg::dlr_status_t               status,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   start_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   start_y,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   end_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   end_y,
    input  wire logic [dlr_pkg::COLOR_W-1:0]   pen_color,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               pixel_valid,
    output logic [dlr_pkg::FIELD_W-1:0]        pixel_x,
    output logic [dlr_pkg::FIELD_W-1:0]        pixel_y,
    output logic [dlr_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               last,
    output logic [dlr_pkg::FIELD_W-1:0]        rect_x,
    output logic [dlr_pkg::FIELD_W-1:0]        rect_y,
    output logic [dlr_pkg::FIELD_W-1:0]        rect_w,
    output logic [dlr_pkg::FIELD_W-1:0]        rect_h
);
    import dlr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int AW = COORD_BITS + 1;

    // Setup of the incoming line.
    logic [CB-1:0] sx, sy, ex, ey;
    logic          mirx_in, miry_in;

    // Latched line description.
    logic [CB-1:0] ox_reg, oy_reg, xl_reg, yl_reg;
    logic          mirx_reg, miry_reg, xmaj_reg;

    // Stepper.
    logic [CB-1:0] step_reg, step_next;
    logic [CB-1:0] minor_pos_reg, minor_pos_next;
    logic [AW-1:0] acc_reg, acc_next, acc_sum;

    // Output register.
    logic                out_valid_reg;
    logic                pixel_valid_reg;
    logic [FIELD_W-1:0]  pixel_x_reg, pixel_y_reg;
    logic [COLOR_W-1:0]  pixel_color_reg;
    logic                last_reg;
    logic [FIELD_W-1:0]  rect_x_reg, rect_y_reg, rect_w_reg, rect_h_reg;

    logic [CB-1:0] major, minor;
    logic [CB-1:0] off_x, off_y, px, py, rw, rh;
    logic          zero_len, last_step, final_step;

    assign sx      = start_x[CB-1:0];
    assign sy      = start_y[CB-1:0];
    assign ex      = end_x[CB-1:0];
    assign ey      = end_y[CB-1:0];
    assign mirx_in = ex < sx;
    assign miry_in = ey < sy;

    assign major = xmaj_reg ? xl_reg : yl_reg;
    assign minor = xmaj_reg ? yl_reg : xl_reg;

    assign zero_len   = major == '0;
    assign last_step  = step_reg == (major - CB'(1));
    assign final_step = zero_len || last_step;

    // The major axis follows the step counter, the minor axis the DDA position.
    assign off_x = xmaj_reg ? step_reg : minor_pos_reg;
    assign off_y = xmaj_reg ? minor_pos_reg : step_reg;
    assign px    = ox_reg + (mirx_reg ? (xl_reg - CB'(1) - off_x) : off_x);
    assign py    = oy_reg + (miry_reg ? (yl_reg - CB'(1) - off_y) : off_y);
    assign rw    = (xl_reg == '0) ? CB'(1) : xl_reg;
    assign rh    = (yl_reg == '0) ? CB'(1) : yl_reg;

    // Remainder stays below major, so one conditional subtract suffices.
    assign acc_sum = acc_reg + AW'(minor);

    always_comb
    begin
        step_next      = step_reg + CB'(1);
        acc_next       = acc_sum;
        minor_pos_next = minor_pos_reg;
        if (acc_sum >= AW'(major))
        begin
            acc_next       = acc_sum - AW'(major);
            minor_pos_next = minor_pos_reg + CB'(1);
        end
    end

    // Line registers and stepper.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            minor_pos_reg <= '0;
            acc_reg       <= '0;
        end
        else if (cmd.load)
        begin
            step_reg      <= '0;
            minor_pos_reg <= '0;
            acc_reg       <= '0;
        end
        else if (cmd.emit)
        begin
            step_reg      <= step_next;
            minor_pos_reg <= minor_pos_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mirx_reg <= mirx_in;
            miry_reg <= miry_in;
            ox_reg   <= mirx_in ? ex : sx;
            oy_reg   <= miry_in ? ey : sy;
            xl_reg   <= mirx_in ? (sx - ex) : (ex - sx);
            yl_reg   <= miry_in ? (sy - ey) : (ey - sy);
            // Equal spans take x as the major axis.
            xmaj_reg <= (mirx_in ? (sx - ex) : (ex - sx)) >=
                        (miry_in ? (sy - ey) : (ey - sy));
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_valid_reg <= !zero_len;
            pixel_x_reg     <= zero_len ? '0 : FIELD_W'(px);
            pixel_y_reg     <= zero_len ? '0 : FIELD_W'(py);
            pixel_color_reg <= zero_len ? '0 : pen_color;
            last_reg        <= final_step;
            rect_x_reg      <= final_step ? FIELD_W'(ox_reg) : '0;
            rect_y_reg      <= final_step ? FIELD_W'(oy_reg) : '0;
            rect_w_reg      <= final_step ? FIELD_W'(rw) : '0;
            rect_h_reg      <= final_step ? FIELD_W'(rh) : '0;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.final_step = final_step;

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;
    assign rect_x      = rect_x_reg;
    assign rect_y      = rect_y_reg;
    assign rect_w      = rect_w_reg;
    assign rect_h      = rect_h_reg;

endmodule

`default_nettype wire

### sv/dda_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core: a line of major span N (N >= 1) gives N results;
// the first is registered by the first emit after the request is accepted,
// once the sequencer finds the output register free.
// Reset clears the sequencer, the stepper, output valid and pen_color.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dda_line_rasterizer_core_assert.svh"

// The block rasterizes one line segment per request. On acceptance the
// datapath latches the bounding box origin, the two spans, the mirror flags
// and the major axis. The controller then issues one emit per cycle in which
// the output register is free; each emit writes one pixel and advances an
// exact integer DDA (remainder accumulator plus minor position), so the minor
// coordinate equals floor(i*minor/major). The final result also carries the
// change rectangle. A zero-length line produces one result without a pixel.
// The pacing is set by the single stepper, one pixel per cycle while the
// output register is free. A new request is taken as soon as the final
// result sits in the output register, while it still waits for the consumer.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Request channel.
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dlr_pkg::FIELD_W-1:0]      start_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]      start_y,
    input  wire logic [dlr_pkg::FIELD_W-1:0]      end_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]      end_y,
    // Result channel.
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  pixel_valid,
    output logic [dlr_pkg::FIELD_W-1:0]           pixel_x,
    output logic [dlr_pkg::FIELD_W-1:0]           pixel_y,
    output logic [dlr_pkg::COLOR_W-1:0]           pixel_color,
    output logic                                  last,
    output logic [dlr_pkg::FIELD_W-1:0]           rect_x,
    output logic [dlr_pkg::FIELD_W-1:0]           rect_y,
    output logic [dlr_pkg::FIELD_W-1:0]           rect_w,
    output logic [dlr_pkg::FIELD_W-1:0]           rect_h,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dlr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dlr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dlr_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import dlr_pkg::*;

    dlr_cmd_t           cmd;
    dlr_status_t        status;
    logic [COLOR_W-1:0] pen_color_reg;
    logic               cfg_write;
    logic [APB_ADDR_W-1:0] paddr_unused;

    // Only one register exists, so the address carries just the byte offset
    // within it and every write lands on pen_color.
    assign paddr_unused = paddr;
    assign cfg_write    = psel && penable && pwrite;
    assign pready       = 1'b1;
    assign prdata       = APB_DATA_W'(pen_color_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_color_reg <= '0;
        end
        else if (cfg_write)
        begin
            pen_color_reg <= pwdata[COLOR_W-1:0];
        end
    end

    dlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dlr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .pen_color   (pen_color_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h)
    );

    // An accepted request leaves the block busy in the following cycle.
    `DLR_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")
    // A result without a pixel only comes from a zero-length line, which ends it.
    `DLR_ASSERT_NOW(a_nopix_is_last, out_valid && !pixel_valid, last, "pixel-less result not last")
    // The change rectangle of a zero-length line is a single point.
    `DLR_ASSERT_NOW(a_nopix_rect, out_valid && !pixel_valid,
        (rect_w == FIELD_W'(1)) && (rect_h == FIELD_W'(1)), "zero-length rectangle wrong")
    // The final result always carries a rectangle of nonzero size.
    `DLR_ASSERT_NOW(a_last_rect, out_valid && last,
        (rect_w != '0) && (rect_h != '0), "empty change rectangle")
    // Results before the final one carry no rectangle.
    `DLR_ASSERT_NOW(a_mid_rect, out_valid && !last,
        (rect_w == '0) && (rect_h == '0) && pixel_valid, "rectangle on inner result")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the DDA line rasterizer core
// Sends line segments over the request channel and checks every result
// against an internal rasterizer model kept by a small scoreboard. The pen
// color is changed between phases. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dlr_pkg::*;

    localparam int COORD_BITS    = 6;
    // Cycles with no accepted request, result or register write before the
    // run is declared hung. The longest legal quiet stretch is a long sender
    // gap or a long receiver stall plus the pipeline latency, so this is far
    // beyond any correct run.
    localparam int QUIET_LIMIT   = 4000;
    // The sequencer returns to idle as it writes the final result, so once
    // the last result has been taken the block is certainly idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 60;

    // Register map: one register, at byte address 0.
    typedef enum logic [APB_ADDR_W-1:0] {
        REG_PEN_COLOR = 2'd0
    } reg_addr_t;

    // One line segment as it travels on the request channel.
    typedef struct packed {
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] ex;
        logic [FIELD_W-1:0] ey;
    } segment_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic               pixel_valid;
        logic [FIELD_W-1:0] pixel_x;
        logic [FIELD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
        logic [FIELD_W-1:0] rect_x;
        logic [FIELD_W-1:0] rect_y;
        logic [FIELD_W-1:0] rect_w;
        logic [FIELD_W-1:0] rect_h;
    } pixel_t;

    // Scoreboard: rasterizes every accepted segment into the pixels it should
    // produce and checks the block's results against them in order.
    class raster_scoreboard;
        logic [COLOR_W-1:0] pen;
        pixel_t             pixel_queue[$];
        int                 errors;

        function new();
            pen    = '0;
            errors = 0;
        endfunction

        function void set_pen(logic [COLOR_W-1:0] color);
            pen = color;
        endfunction

        function int pending();
            return pixel_queue.size();
        endfunction

        // Walk the major axis one step at a time. The minor position follows
        // floor(i*minor/major) through an exact remainder accumulator, and an
        // axis whose end lies below its start is mirrored inside the box.
        function void note_segment(segment_t s);
            logic               mir_x;
            logic               mir_y;
            logic               x_major;
            logic [FIELD_W-1:0] org_x;
            logic [FIELD_W-1:0] org_y;
            logic [FIELD_W-1:0] span_x;
            logic [FIELD_W-1:0] span_y;
            logic [FIELD_W-1:0] major;
            logic [FIELD_W-1:0] minor;
            logic [FIELD_W-1:0] step;
            logic [FIELD_W-1:0] minor_step;
            logic [FIELD_W:0]   remainder;
            pixel_t             p;

            mir_x   = s.ex < s.sx;
            mir_y   = s.ey < s.sy;
            org_x   = mir_x ? s.ex : s.sx;
            org_y   = mir_y ? s.ey : s.sy;
            span_x  = mir_x ? s.sx - s.ex : s.ex - s.sx;
            span_y  = mir_y ? s.sy - s.ey : s.ey - s.sy;
            x_major = span_x >= span_y;
            major   = x_major ? span_x : span_y;
            minor   = x_major ? span_y : span_x;

            if (major == 0)
            begin
                // A single point draws nothing but still reports its box.
                p             = '0;
                p.last        = 1'b1;
                p.rect_x      = org_x;
                p.rect_y      = org_y;
                p.rect_w      = 6'd1;
                p.rect_h      = 6'd1;
                pixel_queue.push_back(p);
                return;
            end

            remainder  = '0;
            minor_step = '0;
            step       = '0;
            do
            begin
                p             = '0;
                p.pixel_valid = 1'b1;
                p.pixel_color = pen;
                if (x_major)
                begin
                    p.pixel_x = org_x + (mir_x ? span_x - 6'd1 - step : step);
                    p.pixel_y = org_y + (mir_y ? span_y - 6'd1 - minor_step : minor_step);
                end
                else
                begin
                    p.pixel_x = org_x + (mir_x ? span_x - 6'd1 - minor_step : minor_step);
                    p.pixel_y = org_y + (mir_y ? span_y - 6'd1 - step : step);
                end
                if (step + 6'd1 == major)
                begin
                    p.last   = 1'b1;
                    p.rect_x = org_x;
                    p.rect_y = org_y;
                    p.rect_w = (span_x == 0) ? 6'd1 : span_x;
                    p.rect_h = (span_y == 0) ? 6'd1 : span_y;
                end
                pixel_queue.push_back(p);
                remainder = remainder + minor;
                if (remainder >= major)
                begin
                    remainder  = remainder - major;
                    minor_step = minor_step + 6'd1;
                end
                step = step + 6'd1;
            end
            while (step != major);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;

            if (pixel_queue.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pixel_queue.pop_front();
            check_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
            check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
            check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
            check_field("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
            check_field("last", 32'(want.last), 32'(got.last));
            check_field("rect_x", 32'(want.rect_x), 32'(got.rect_x));
            check_field("rect_y", 32'(want.rect_y), 32'(got.rect_y));
            check_field("rect_w", 32'(want.rect_w), 32'(got.rect_w));
            check_field("rect_h", 32'(want.rect_h), 32'(got.rect_h));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [FIELD_W-1:0]    start_x;
    logic [FIELD_W-1:0]    start_y;
    logic [FIELD_W-1:0]    end_x;
    logic [FIELD_W-1:0]    end_y;
    logic                  out_valid;
    logic                  out_ready;
    logic                  pixel_valid;
    logic [FIELD_W-1:0]    pixel_x;
    logic [FIELD_W-1:0]    pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last;
    logic [FIELD_W-1:0]    rect_x;
    logic [FIELD_W-1:0]    rect_y;
    logic [FIELD_W-1:0]    rect_w;
    logic [FIELD_W-1:0]    rect_h;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    raster_scoreboard sb;
    // When set, neither side inserts gaps, so the block runs at full rate.
    logic             no_idle;
    int               quiet_cycles;

    dda_line_rasterizer_core #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic segment_t seg(int sx, int sy, int ex, int ey);
        segment_t s;

        s.sx = FIELD_W'(sx);
        s.sy = FIELD_W'(sy);
        s.ex = FIELD_W'(ex);
        s.ey = FIELD_W'(ey);
        return s;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > 63)
            return 63;
        return v;
    endfunction

    // Random segments: points, axis-aligned and diagonal lines, short lines
    // and fully random ones, so that every octant and both spans are covered.
    function automatic segment_t random_segment();
        segment_t s;
        int       kind;
        int       len;

        kind = $urandom_range(0, 99);
        s    = seg($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
        if (kind < 8)
        begin
            s.ex = s.sx;
            s.ey = s.sy;
        end
        else if (kind < 16)
            s.ey = s.sy;
        else if (kind < 24)
            s.ex = s.sx;
        else if (kind < 34)
        begin
            len  = $urandom_range(1, 63);
            s.ex = FIELD_W'(clamp_coord(int'(s.sx) + ($urandom_range(0, 1) ? len : -len)));
            s.ey = FIELD_W'(clamp_coord(int'(s.sy) + ($urandom_range(0, 1) ? len : -len)));
        end
        else if (kind < 60)
        begin
            s.ex = FIELD_W'(clamp_coord(int'(s.sx) + int'($urandom_range(0, 12)) - 6));
            s.ey = FIELD_W'(clamp_coord(int'(s.sy) + int'($urandom_range(0, 12)) - 6));
        end
        return s;
    endfunction

    // Offers one request and returns at the edge where it is accepted. Valid
    // is only lowered when a gap comes first, so back-to-back requests keep
    // it high without a glitch.
    task automatic send_segment(input segment_t s, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= s.sx;
        start_y  <= s.sy;
        end_x    <= s.ex;
        end_y    <= s.ey;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Register write: a setup cycle, then the access cycle.
    task automatic write_reg(input reg_addr_t addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops sending, waits for every expected result and lets the block
    // settle, so that a register write that follows finds it idle.
    task automatic finish_phase();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: ready bursts broken by stalls of random length.
    initial
    begin
        int burst;
        int stall;

        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            burst = $urandom_range(1, 24);
            stall = pick_gap();
            out_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Monitor: every handshake is taken from the values that stood before
    // the edge. Accepted requests and register writes feed the scoreboard,
    // accepted results are checked, and a watchdog ends a hung run.
    always @(posedge clk)
    begin
        pixel_t seen;

        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_PEN_COLOR)
                sb.set_pen(pwdata[COLOR_W-1:0]);
            if (in_valid && in_ready)
                sb.note_segment(seg(int'(start_x), int'(start_y), int'(end_x), int'(end_y)));
            if (out_valid && out_ready)
            begin
                seen.pixel_valid = pixel_valid;
                seen.pixel_x     = pixel_x;
                seen.pixel_y     = pixel_y;
                seen.pixel_color = pixel_color;
                seen.last        = last;
                seen.rect_x      = rect_x;
                seen.rect_y      = rect_y;
                seen.rect_w      = rect_w;
                seen.rect_h      = rect_h;
                sb.check_pixel(seen);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [COLOR_W-1:0] phase_pen;

        sb       = new();
        no_idle  = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        start_x  = '0;
        start_y  = '0;
        end_x    = '0;
        end_y    = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = REG_PEN_COLOR;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines with the pen color still at its reset value: single
        // points at both corners and a full-length horizontal line.
        send_segment(seg(0, 0, 0, 0), pick_gap());
        send_segment(seg(63, 63, 63, 63), pick_gap());
        send_segment(seg(0, 0, 63, 0), pick_gap());
        finish_phase();

        // Remaining directed lines with every color bit set: reversed and
        // vertical lines, the four full diagonals (equal spans step along x),
        // steep and shallow lines in both x directions and the shortest lines.
        write_reg(REG_PEN_COLOR, 32'h00FF_FFFF);
        send_segment(seg(63, 5, 0, 5), pick_gap());
        send_segment(seg(10, 0, 10, 63), pick_gap());
        send_segment(seg(20, 63, 20, 0), pick_gap());
        send_segment(seg(0, 0, 63, 63), pick_gap());
        send_segment(seg(63, 0, 0, 63), pick_gap());
        send_segment(seg(0, 63, 63, 0), pick_gap());
        send_segment(seg(63, 63, 0, 0), pick_gap());
        send_segment(seg(5, 60, 9, 2), pick_gap());
        send_segment(seg(2, 3, 50, 17), pick_gap());
        send_segment(seg(50, 10, 3, 20), pick_gap());
        send_segment(seg(40, 50, 30, 1), pick_gap());
        send_segment(seg(12, 30, 14, 62), pick_gap());
        send_segment(seg(1, 62, 62, 1), pick_gap());
        send_segment(seg(0, 0, 1, 0), pick_gap());
        send_segment(seg(0, 0, 0, 1), pick_gap());
        send_segment(seg(7, 7, 8, 8), pick_gap());
        send_segment(seg(33, 21, 32, 20), pick_gap());
        send_segment(seg(0, 63, 0, 63), pick_gap());
        send_segment(seg(63, 0, 63, 0), pick_gap());
        finish_phase();

        // Random phases, each under its own pen color. Two of them run with
        // no idling on either side to hold the block at full rate.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: phase_pen = 24'h000000;
                3: phase_pen = 24'h800001;
                5: phase_pen = 24'hFFFFFF;
                default: phase_pen = COLOR_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            write_reg(REG_PEN_COLOR, {8'h00, phase_pen});
            no_idle = (phase == 2 || phase == 4);
            repeat (PHASE_ITEMS) send_segment(random_segment(), pick_gap());
            finish_phase();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
